>>> design/assert_macros.svh
// Assertion macros shared by the wheel speed mixer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition holds at every clock edge outside reset.
`define MWSM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Checks that a condition implies another in the same cycle.
`define MWSM_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`endif

>>> design/mwsm_pkg.sv
// Package with types, constants and helpers of the mecanum wheel speed mixer.
`timescale 1ns / 1ps
package mwsm_pkg;

  localparam int WHEEL_FRAC_BITS_DEF = 8;
  localparam int CMD_W      = 18;
  localparam int LIM_W      = 17;
  localparam int LEV_W      = 24;
  localparam int LEVER_W    = 27;
  localparam int RATIO_W    = 32;
  localparam int WLIM_W     = 15;
  localparam int SPEED_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam int OUT_DEPTH   = 32;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 24'h7FFFFF;

  localparam logic [LIM_W-1:0]   LIMIT_VX_RST   = 17'd50000;
  localparam logic [LIM_W-1:0]   LIMIT_VY_RST   = 17'd50000;
  localparam logic [LIM_W-1:0]   LIMIT_YAW_RST  = 17'd50000;
  localparam logic [LEV_W-1:0]   LEVER_BASE_RST = 24'd343121;
  localparam logic [LEV_W-1:0]   LEVER_OFS_RST  = 24'd0;
  localparam logic [RATIO_W-1:0] RPM_RATIO_RST  = 32'd1773568;
  localparam logic [WLIM_W-1:0]  WHEEL_LIM_RST  = 15'd8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_VX,
    REG_LIMIT_VY,
    REG_LIMIT_YAW,
    REG_LEVER_BASE,
    REG_LEVER_X_OFS,
    REG_LEVER_Y_OFS,
    REG_RPM_RATIO,
    REG_WHEEL_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic [LIM_W-1:0]   limit_vx;
    logic [LIM_W-1:0]   limit_vy;
    logic [LIM_W-1:0]   limit_yaw;
    logic [LEV_W-1:0]   lever_base;
    logic [LEV_W-1:0]   lever_x_offset;
    logic [LEV_W-1:0]   lever_y_offset;
    logic [RATIO_W-1:0] rpm_ratio;
    logic [WLIM_W-1:0]  wheel_limit;
  } cfg_t;

  // Clamps a command part to the range from -lim to +lim.
  function automatic logic signed [CMD_W-1:0] clamp_sym(input logic signed [CMD_W-1:0] v,
                                                        input logic [LIM_W-1:0] lim);
    logic signed [CMD_W:0]   v_w;
    logic signed [CMD_W:0]   l_w;
    logic signed [CMD_W-1:0] r;
    v_w = (CMD_W+1)'(v);
    l_w = signed'({2'b00, lim});
    if (v_w < -l_w) begin
      r = CMD_W'(-l_w);
    end else if (v_w > l_w) begin
      r = CMD_W'(l_w);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/mecanum_wheel_speed_mixer.sv
// Throughput: one command per cycle while in_stall_o is low; the 16-entry queue between
//   front and back and the 32-entry output queue can fill and then stall the input.
// The divider is pipelined and restoring, one quotient bit per stage, 15 + WHEEL_FRAC_BITS deep.
// Reset is asynchronous, active low; it empties all queues and loads the default registers.
`timescale 1ns / 1ps
module mecanum_wheel_speed_mixer
  import mwsm_pkg::*;
#(
  parameter int WHEEL_FRAC_BITS = WHEEL_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [CMD_W-1:0]   cmd_vx_i,
  input  logic signed [CMD_W-1:0]   cmd_vy_i,
  input  logic signed [CMD_W-1:0]   cmd_yaw_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SPEED_W-1:0] speed_front_right_o,
  output logic signed [SPEED_W-1:0] speed_front_left_o,
  output logic signed [SPEED_W-1:0] speed_back_left_o,
  output logic signed [SPEED_W-1:0] speed_back_right_o,
  output logic                      was_scaled_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);
  localparam int MAGW = 32 + WHEEL_FRAC_BITS;
  localparam int PW = 5 * MAGW + 5;
  localparam int OW = 4 * SPEED_W + 1;

  cfg_t          cfg_q;
  logic          q_push, q_pop, q_empty;
  logic [PW-1:0] q_wdata, q_rdata;
  logic          o_push, o_pop, o_empty;
  logic [OW-1:0] o_wdata, o_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_vx       <= LIMIT_VX_RST;
      cfg_q.limit_vy       <= LIMIT_VY_RST;
      cfg_q.limit_yaw      <= LIMIT_YAW_RST;
      cfg_q.lever_base     <= LEVER_BASE_RST;
      cfg_q.lever_x_offset <= LEVER_OFS_RST;
      cfg_q.lever_y_offset <= LEVER_OFS_RST;
      cfg_q.rpm_ratio      <= RPM_RATIO_RST;
      cfg_q.wheel_limit    <= WHEEL_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LIMIT_VX:    cfg_q.limit_vx       <= cfg_data_i[LIM_W-1:0];
        REG_LIMIT_VY:    cfg_q.limit_vy       <= cfg_data_i[LIM_W-1:0];
        REG_LIMIT_YAW:   cfg_q.limit_yaw      <= cfg_data_i[LIM_W-1:0];
        REG_LEVER_BASE:  cfg_q.lever_base     <= cfg_data_i[LEV_W-1:0];
        REG_LEVER_X_OFS: cfg_q.lever_x_offset <= cfg_data_i[LEV_W-1:0];
        REG_LEVER_Y_OFS: cfg_q.lever_y_offset <= cfg_data_i[LEV_W-1:0];
        REG_RPM_RATIO:   cfg_q.rpm_ratio      <= cfg_data_i[RATIO_W-1:0];
        REG_WHEEL_LIMIT: cfg_q.wheel_limit    <= cfg_data_i[WLIM_W-1:0];
        default: ;
      endcase
    end
  end

  mwsm_front #(
    .WHEEL_FRAC_BITS(WHEEL_FRAC_BITS),
    .QDEPTH         (QUEUE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_vx_i  (cmd_vx_i),
    .cmd_vy_i  (cmd_vy_i),
    .cmd_yaw_i (cmd_yaw_i),
    .cfg_i     (cfg_q),
    .q_pop_i   (q_pop),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  mwsm_fifo #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(PW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  mwsm_back #(
    .WHEEL_FRAC_BITS(WHEEL_FRAC_BITS),
    .ODEPTH         (OUT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (!q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .wheel_limit_i(cfg_q.wheel_limit),
    .o_push_o     (o_push),
    .o_data_o     (o_wdata),
    .o_pop_i      (o_pop)
  );

  mwsm_fifo #(
    .DEPTH(OUT_DEPTH),
    .WIDTH(OW)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (o_push),
    .data_i (o_wdata),
    .pop_i  (o_pop),
    .data_o (o_rdata),
    .empty_o(o_empty)
  );

  assign out_valid_o         = !o_empty;
  assign o_pop               = out_valid_o && !out_stall_i;
  assign speed_front_right_o = o_rdata[0*SPEED_W +: SPEED_W];
  assign speed_front_left_o  = o_rdata[1*SPEED_W +: SPEED_W];
  assign speed_back_left_o   = o_rdata[2*SPEED_W +: SPEED_W];
  assign speed_back_right_o  = o_rdata[3*SPEED_W +: SPEED_W];
  assign was_scaled_o        = o_rdata[OW-1];
endmodule

>>> design/mwsm_fifo.sv
// Small first-in first-out queue with a combinational head.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mwsm_fifo #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? wptr_q + PW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);

  `MWSM_ASSERT_IMP(a_no_overflow, push_i, cnt_q < CW'(DEPTH) || pop_i, "fifo overflow")
  `MWSM_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "fifo underflow")
endmodule

>>> design/mwsm_front.sv
// Front part: clamps the command, mixes it into wheel magnitudes and finds the largest.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mwsm_front
  import mwsm_pkg::*;
#(
  parameter int WHEEL_FRAC_BITS = WHEEL_FRAC_BITS_DEF,
  parameter int QDEPTH = QUEUE_DEPTH,
  localparam int MAGW = 32 + WHEEL_FRAC_BITS,
  localparam int PW = 5 * MAGW + 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CMD_W-1:0] cmd_vx_i,
  input  logic signed [CMD_W-1:0] cmd_vy_i,
  input  logic signed [CMD_W-1:0] cmd_yaw_i,
  input  cfg_t                    cfg_i,
  input  logic                    q_pop_i,
  output logic                    q_push_o,
  output logic [PW-1:0]           q_data_o
);
  localparam int CW = $clog2(QDEPTH + 1);
  localparam int LIMW = WLIM_W + WHEEL_FRAC_BITS;

  logic          accept;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [6:0]    v_q;

  logic signed [CMD_W-1:0]   vx_q, vy_q, vw_q;
  logic signed [LEVER_W-1:0] lever [4];
  logic signed [CMD_W:0]     lin_d [4], lin_q [4];
  logic signed [44:0]        p_d [4], p_q [4];
  logic signed [45:0]        s [4];
  logic [42:0]               a_q [4];
  logic [3:0]                n2_q, n3_q, n4_q, n5_q, n6_q;
  logic [58:0]               hi_q [4], lo_q [4];
  logic [59:0]               sum [4];
  logic [MAGW-1:0]           m4_q [4], m5_q [4], m6_q [4];
  logic [MAGW-1:0]           m01_q, m23_q, mx_q, mx_d;
  logic                      scaled_q;
  logic [LIMW-1:0]           lim;

  assign in_stall_o = (cnt_q == CW'(QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_d      = cnt_q + CW'(accept) - CW'(q_pop_i);
  assign lim        = LIMW'(cfg_i.wheel_limit) << WHEEL_FRAC_BITS;

  always_comb begin
    logic signed [LEVER_W-1:0] base, xo, yo;
    logic signed [CMD_W:0]     vx, vy;
    base = signed'({3'b000, cfg_i.lever_base});
    xo   = LEVER_W'(signed'(cfg_i.lever_x_offset));
    yo   = LEVER_W'(signed'(cfg_i.lever_y_offset));
    lever[0] = base - xo + yo;
    lever[1] = base - xo - yo;
    lever[2] = base + xo - yo;
    lever[3] = base + xo + yo;
    vx = (CMD_W+1)'(vx_q);
    vy = (CMD_W+1)'(vy_q);
    lin_d[0] = vy - vx;
    lin_d[1] = vx + vy;
    lin_d[2] = vx - vy;
    lin_d[3] = -vx - vy;
    for (int i = 0; i < 4; i++) begin
      p_d[i] = vw_q * lever[i];
      s[i]   = (46'(lin_q[i]) <<< 16) + 46'(p_q[i]);
      sum[i] = hi_q[i] + 60'(lo_q[i] >> 16);
    end
    mx_d = (m01_q > m23_q) ? m01_q : m23_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      v_q   <= {v_q[5:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q <= clamp_sym(cmd_vx_i, cfg_i.limit_vx);
      vy_q <= clamp_sym(cmd_vy_i, cfg_i.limit_vy);
      vw_q <= clamp_sym(cmd_yaw_i, cfg_i.limit_yaw);
    end
    for (int i = 0; i < 4; i++) begin
      lin_q[i] <= lin_d[i];
      p_q[i]   <= p_d[i];
      n2_q[i]  <= s[i][45];
      a_q[i]   <= s[i][45] ? 43'(-s[i]) : s[i][42:0];
      hi_q[i]  <= a_q[i] * cfg_i.rpm_ratio[31:16];
      lo_q[i]  <= a_q[i] * cfg_i.rpm_ratio[15:0];
      m4_q[i]  <= sum[i][59 -: MAGW];
      m5_q[i]  <= m4_q[i];
      m6_q[i]  <= m5_q[i];
    end
    n3_q     <= n2_q;
    n4_q     <= n3_q;
    n5_q     <= n4_q;
    n6_q     <= n5_q;
    m01_q    <= (m4_q[0] > m4_q[1]) ? m4_q[0] : m4_q[1];
    m23_q    <= (m4_q[2] > m4_q[3]) ? m4_q[2] : m4_q[3];
    mx_q     <= mx_d;
    scaled_q <= mx_d > MAGW'(lim);
  end

  assign q_push_o = v_q[6];
  assign q_data_o = {scaled_q, mx_q, n6_q, m6_q[3], m6_q[2], m6_q[1], m6_q[0]};

  `MWSM_ASSERT(a_credit_bound, cnt_q <= CW'(QDEPTH), "front credit count above queue depth")
endmodule

>>> design/mwsm_back.sv
// Back part: scales the wheels down by limit over max with a pipelined divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mwsm_back
  import mwsm_pkg::*;
#(
  parameter int WHEEL_FRAC_BITS = WHEEL_FRAC_BITS_DEF,
  parameter int ODEPTH = OUT_DEPTH,
  localparam int MAGW = 32 + WHEEL_FRAC_BITS,
  localparam int PW = 5 * MAGW + 5,
  localparam int OW = 4 * SPEED_W + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  logic [PW-1:0]     q_data_i,
  output logic              q_pop_o,
  input  logic [WLIM_W-1:0] wheel_limit_i,
  output logic              o_push_o,
  output logic [OW-1:0]     o_data_o,
  input  logic              o_pop_i
);
  localparam int QB = WLIM_W + WHEEL_FRAC_BITS;
  localparam int CW = $clog2(ODEPTH + 1);
  localparam int NW = MAGW + QB;

  logic [CW-1:0]   cnt_q, cnt_d;
  logic [QB-1:0]   lim;
  logic            pv_q;
  logic [NW-1:0]   prod_q [4];
  logic [MAGW-1:0] pmag_q [4];
  logic [3:0]      pneg_q;
  logic [MAGW-1:0] pmx_q;
  logic            pscl_q;

  logic            dv_q   [QB+1];
  logic [MAGW-1:0] rem_q  [QB+1][4];
  logic [QB-1:0]   low_q  [QB+1][4];
  logic [QB-1:0]   quo_q  [QB+1][4];
  logic [MAGW-1:0] mag_q  [QB+1][4];
  logic [3:0]      neg_q  [QB+1];
  logic [MAGW-1:0] mx_q   [QB+1];
  logic            scl_q  [QB+1];

  logic [SPEED_W-1:0] spd [4];

  assign q_pop_o = q_valid_i && (cnt_q < CW'(ODEPTH));
  assign cnt_d   = cnt_q + CW'(q_pop_o) - CW'(o_pop_i);
  assign lim     = QB'(wheel_limit_i) << WHEEL_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pv_q  <= 1'b0;
      dv_q[0] <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pv_q  <= q_pop_o;
      dv_q[0] <= pv_q;
    end
  end

  // The product of each magnitude and the limit is the dividend.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      prod_q[i] <= q_data_i[i*MAGW +: MAGW] * lim;
      pmag_q[i] <= q_data_i[i*MAGW +: MAGW];
      rem_q[0][i] <= prod_q[i][NW-1:QB];
      low_q[0][i] <= prod_q[i][QB-1:0];
      quo_q[0][i] <= '0;
      mag_q[0][i] <= pmag_q[i];
    end
    pneg_q   <= q_data_i[4*MAGW +: 4];
    pmx_q    <= q_data_i[4*MAGW+4 +: MAGW];
    pscl_q   <= q_data_i[PW-1];
    neg_q[0] <= pneg_q;
    mx_q[0]  <= pmx_q;
    scl_q[0] <= pscl_q;
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [MAGW:0]   r2 [4];
    logic            ge [4];
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        r2[i] = {rem_q[j][i], low_q[j][i][QB-1-j]};
        ge[i] = r2[i] >= {1'b0, mx_q[j]};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else begin
        dv_q[j+1] <= dv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 4; i++) begin
        rem_q[j+1][i] <= ge[i] ? MAGW'(r2[i] - {1'b0, mx_q[j]}) : MAGW'(r2[i]);
        quo_q[j+1][i] <= {quo_q[j][i][QB-2:0], ge[i]};
        low_q[j+1][i] <= low_q[j][i];
        mag_q[j+1][i] <= mag_q[j][i];
      end
      neg_q[j+1] <= neg_q[j];
      mx_q[j+1]  <= mx_q[j];
      scl_q[j+1] <= scl_q[j];
    end
  end

  always_comb begin
    logic [MAGW-1:0]    m;
    logic [SPEED_W-1:0] ms;
    for (int i = 0; i < 4; i++) begin
      m  = scl_q[QB] ? MAGW'(quo_q[QB][i]) : mag_q[QB][i];
      ms = (m > MAGW'(SPEED_MAX)) ? SPEED_MAX : m[SPEED_W-1:0];
      spd[i] = neg_q[QB][i] ? -ms : ms;
    end
  end

  assign o_push_o = dv_q[QB];
  assign o_data_o = {scl_q[QB], spd[3], spd[2], spd[1], spd[0]};

  `MWSM_ASSERT_IMP(a_quot_le_limit, dv_q[QB] && scl_q[QB],
                   quo_q[QB][0] <= lim && quo_q[QB][1] <= lim &&
                   quo_q[QB][2] <= lim && quo_q[QB][3] <= lim,
                   "scaled wheel speed above the wheel limit")
endmodule
